// ----- hw/rtl/bmp_rle_decoder_assert.svh -----
// ----------------------------------------------------------------------------
// BMP RLE decoder assertion macros
// Shared forms for the concurrent checks of the decoder, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BMP_RLE_DECODER_ASSERT_SVH
`define BMP_RLE_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BMP_RLE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmp_rle_decoder: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BMP_RLE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmp_rle_decoder: next-cycle check failed");

`endif

// ----- hw/rtl/bmp_rle_pkg.sv -----
// ----------------------------------------------------------------------------
// BMP RLE decoder package
// Result kinds, escape codes, register indexes and the command record that
// travels from the parser to the output stage.
// ----------------------------------------------------------------------------
package bmp_rle_pkg;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_RUN        = 2'd0;
    localparam kind_t KIND_END_OF_BMP = 2'd1;
    localparam kind_t KIND_TRUNCATED  = 2'd2;

    localparam logic [7:0] ESC_END_OF_LINE = 8'd0;
    localparam logic [7:0] ESC_END_OF_BMP  = 8'd1;
    localparam logic [7:0] ESC_DELTA       = 8'd2;

    // Register index, taken from paddr[2].
    localparam logic REG_RLE4_MODE     = 1'b0;
    localparam logic REG_SIGNED_HEIGHT = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;

    // One entry per byte that produces results: an optional pixel run taken
    // at the cursor before the byte, then an optional status at the cursor
    // after it.
    typedef struct packed {
        logic               has_run;
        logic [15:0]        run_x;
        logic signed [16:0] run_y;
        logic [7:0]         run_len;
        logic [7:0]         run_even;
        logic [7:0]         run_odd;
        logic               has_stat;
        kind_t              stat_kind;
        logic [15:0]        stat_x;
        logic signed [16:0] stat_y;
    } rle_cmd_t;

    typedef struct packed {
        logic not_empty;
        logic has_space;
    } queue_stat_t;

endpackage

// ----- hw/rtl/bmp_rle_if.sv -----
// ----------------------------------------------------------------------------
// BMP RLE decoder channels
// Valid/ready interfaces for the compressed byte stream and the result stream.
// ----------------------------------------------------------------------------
interface bmp_rle_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_data;

    modport source (output valid, output data_byte, output end_of_data, input ready);
    modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface bmp_rle_result_if
    import bmp_rle_pkg::*;
;
    logic               valid;
    logic               ready;
    kind_t              kind;
    logic [15:0]        start_x;
    logic signed [16:0] row_y;
    logic [7:0]         run_length;
    logic [7:0]         even_index;
    logic [7:0]         odd_index;
    logic               last_of_item;

    modport source (output valid, output kind, output start_x, output row_y,
                    output run_length, output even_index, output odd_index,
                    output last_of_item, input ready);
    modport sink   (input valid, input kind, input start_x, input row_y,
                    input run_length, input even_index, input odd_index,
                    input last_of_item, output ready);
endinterface

// ----- hw/rtl/bmp_rle_front.sv -----
// ----------------------------------------------------------------------------
// BMP RLE decoder front end
// Byte-pair parser: keeps the escape state and the cursor, and turns every
// accepted byte into at most one command for the output queue.
// ----------------------------------------------------------------------------
module bmp_rle_front
    import bmp_rle_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               restart,
    input  logic               rle4_mode,
    input  logic signed [16:0] signed_height,
    input  logic               in_valid,
    input  logic [7:0]         data_byte,
    input  logic               end_of_data,
    output logic               in_ready,
    input  logic               q_space,
    output logic               push,
    output rle_cmd_t           cmd,
    output logic               finished
);

    localparam int WW = (COORD_BITS + 2 > 18) ? COORD_BITS + 2 : 18;

    localparam logic [2:0] PH_COUNT  = 3'd0;
    localparam logic [2:0] PH_VALUE  = 3'd1;
    localparam logic [2:0] PH_ESCAPE = 3'd2;
    localparam logic [2:0] PH_DX     = 3'd3;
    localparam logic [2:0] PH_DY     = 3'd4;
    localparam logic [2:0] PH_ABS    = 3'd5;
    localparam logic [2:0] PH_PAD    = 3'd6;

    localparam logic [COORD_BITS:0] X_SAT = {1'b0, {COORD_BITS{1'b1}}};
    localparam logic signed [WW-1:0] Y_HI = WW'((64'sd1 <<< COORD_BITS) - 64'sd1);
    localparam logic signed [WW-1:0] Y_LO = WW'(-(64'sd1 <<< COORD_BITS));

    function automatic logic [COORD_BITS:0] clamp_y(input logic signed [WW-1:0] v);
        logic signed [WW-1:0] c;
        if (v > Y_HI)
            c = Y_HI;
        else if (v < Y_LO)
            c = Y_LO;
        else
            c = v;
        return c[COORD_BITS:0];
    endfunction

    function automatic logic [15:0] x_field(input logic [COORD_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[15:0];
    endfunction

    function automatic logic [16:0] y_field(input logic signed [COORD_BITS:0] v);
        logic signed [32:0] w;
        w = 33'(v);
        return w[16:0];
    endfunction

    logic [2:0]                   phase_reg, phase_next;
    logic [7:0]                   saved_reg, saved_next;
    logic [COORD_BITS-1:0]        x_reg, x_next;
    logic signed [COORD_BITS:0]   y_reg, y_next;
    logic [7:0]                   abs_left_reg, abs_left_next;
    logic                         pad_reg, pad_next;
    logic                         fin_reg, fin_next;

    logic                         accept;
    logic                         h_pos;
    logic signed [WW-1:0]         h_ext;
    logic signed [COORD_BITS:0]   start_y;
    logic [7:0]                   x_amt;
    logic [COORD_BITS:0]          x_sum;
    logic [COORD_BITS-1:0]        x_adv;
    logic [7:0]                   y_amt;
    logic signed [WW-1:0]         y_amt_w;
    logic signed [WW-1:0]         y_sum;
    logic signed [COORD_BITS:0]   y_step;
    logic [7:0]                   abs_len;
    logic [8:0]                   b_plus;
    logic [7:0]                   nib_hi;
    logic [7:0]                   nib_lo;

    assign accept   = in_valid && in_ready;
    assign in_ready = q_space && !restart;
    assign finished = fin_reg;

    // Positive heights run bottom-up from the last row.
    assign h_pos   = !signed_height[16] && (signed_height != 17'sd0);
    assign h_ext   = WW'(signed_height);
    assign start_y = $signed(clamp_y(h_pos ? h_ext - WW'(1) : WW'(0)));

    assign nib_hi = {4'b0000, data_byte[7:4]};
    assign nib_lo = {4'b0000, data_byte[3:0]};
    assign b_plus = {1'b0, data_byte} + 9'd1;
    assign abs_len = (rle4_mode && abs_left_reg >= 8'd2) ? 8'd2 : 8'd1;

    // One shared x adder: run length, delta dx or absolute pixel count.
    always_comb
    begin
        unique case (phase_reg)
            PH_VALUE, PH_DY: x_amt = saved_reg;
            PH_ABS:          x_amt = abs_len;
            default:         x_amt = 8'd0;
        endcase
    end

    assign x_sum = {1'b0, x_reg} + (COORD_BITS + 1)'(x_amt);
    assign x_adv = (x_sum > X_SAT) ? X_SAT[COORD_BITS-1:0] : x_sum[COORD_BITS-1:0];

    // One shared y adder: a single line for end of line, dy for a delta.
    assign y_amt   = (phase_reg == PH_ESCAPE) ? 8'd1 : data_byte;
    assign y_amt_w = $signed(WW'(y_amt));
    assign y_sum   = h_pos ? WW'(y_reg) - y_amt_w : WW'(y_reg) + y_amt_w;
    assign y_step  = $signed(clamp_y(y_sum));

    always_comb
    begin
        phase_next    = phase_reg;
        saved_next    = saved_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        abs_left_next = abs_left_reg;
        pad_next      = pad_reg;
        fin_next      = fin_reg;
        cmd           = '0;

        cmd.run_x = x_field(x_reg);
        cmd.run_y = $signed(y_field(y_reg));

        if (!fin_reg)
        begin
            unique case (phase_reg)
                PH_COUNT:
                begin
                    saved_next = data_byte;
                    phase_next = (data_byte != 8'd0) ? PH_VALUE : PH_ESCAPE;
                end
                PH_VALUE:
                begin
                    cmd.has_run  = 1'b1;
                    cmd.run_len  = saved_reg;
                    cmd.run_even = rle4_mode ? nib_hi : data_byte;
                    cmd.run_odd  = rle4_mode ? nib_lo : data_byte;
                    x_next       = x_adv;
                    phase_next   = PH_COUNT;
                end
                PH_ESCAPE:
                begin
                    phase_next = PH_COUNT;
                    unique case (data_byte)
                        ESC_END_OF_LINE:
                        begin
                            x_next = '0;
                            y_next = y_step;
                        end
                        ESC_END_OF_BMP:
                        begin
                            cmd.has_stat  = 1'b1;
                            cmd.stat_kind = KIND_END_OF_BMP;
                            fin_next      = 1'b1;
                        end
                        ESC_DELTA:
                        begin
                            phase_next = PH_DX;
                        end
                        default:
                        begin
                            // Absolute run; padding keeps the run word aligned.
                            abs_left_next = data_byte;
                            pad_next      = rle4_mode ? b_plus[1] : data_byte[0];
                            phase_next    = PH_ABS;
                        end
                    endcase
                end
                PH_DX:
                begin
                    saved_next = data_byte;
                    phase_next = PH_DY;
                end
                PH_DY:
                begin
                    x_next     = x_adv;
                    y_next     = y_step;
                    phase_next = PH_COUNT;
                end
                PH_ABS:
                begin
                    cmd.has_run  = 1'b1;
                    cmd.run_len  = abs_len;
                    cmd.run_even = rle4_mode ? nib_hi : data_byte;
                    cmd.run_odd  = rle4_mode ? nib_lo : data_byte;
                    x_next       = x_adv;
                    abs_left_next = (abs_left_reg > abs_len) ? abs_left_reg - abs_len : 8'd0;
                    if (abs_left_reg <= abs_len)
                    begin
                        phase_next = pad_reg ? PH_PAD : PH_COUNT;
                        pad_next   = 1'b0;
                    end
                end
                default:
                begin
                    phase_next = PH_COUNT;
                end
            endcase

            if (end_of_data && !fin_next)
            begin
                cmd.has_stat  = 1'b1;
                cmd.stat_kind = KIND_TRUNCATED;
                fin_next      = 1'b1;
            end
        end

        cmd.stat_x = x_field(x_next);
        cmd.stat_y = $signed(y_field(y_next));
    end

    assign push = accept && !fin_reg && (cmd.has_run || cmd.has_stat);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_COUNT;
            saved_reg    <= '0;
            x_reg        <= '0;
            // The height register resets to one row, so the start row is zero.
            y_reg        <= '0;
            abs_left_reg <= '0;
            pad_reg      <= 1'b0;
            fin_reg      <= 1'b0;
        end
        else if (restart)
        begin
            phase_reg    <= PH_COUNT;
            saved_reg    <= '0;
            x_reg        <= '0;
            y_reg        <= start_y;
            abs_left_reg <= '0;
            pad_reg      <= 1'b0;
            fin_reg      <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            saved_reg    <= saved_next;
            x_reg        <= x_next;
            y_reg        <= y_next;
            abs_left_reg <= abs_left_next;
            pad_reg      <= pad_next;
            fin_reg      <= fin_next;
        end
    end

endmodule

// ----- hw/rtl/bmp_rle_queue.sv -----
// ----------------------------------------------------------------------------
// BMP RLE decoder command queue
// Small first-in first-out buffer between the parser and the output stage.
// ----------------------------------------------------------------------------
module bmp_rle_queue
    import bmp_rle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  rle_cmd_t    cmd_in,
    input  logic        pop,
    output rle_cmd_t    cmd_out,
    output queue_stat_t stat
);

    rle_cmd_t                 mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_W:0]     count_reg, count_next;

    assign cmd_out        = mem_reg[rd_ptr_reg];
    assign stat.not_empty = (count_reg != '0);
    assign stat.has_space = (count_reg != (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QUEUE_PTR_W + 1)'(push) - (QUEUE_PTR_W + 1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= cmd_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- hw/rtl/bmp_rle_back.sv -----
// ----------------------------------------------------------------------------
// BMP RLE decoder output stage
// Unpacks each queued command into one or two results and holds the current
// result in an output register until it is transferred.
// ----------------------------------------------------------------------------
module bmp_rle_back
    import bmp_rle_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  rle_cmd_t head,
    input  logic     q_not_empty,
    output logic     pop,
    bmp_rle_result_if.source result_out
);

    logic               valid_reg, valid_next;
    logic               pend_reg, pend_next;
    logic               take;

    kind_t              kind_reg;
    logic [15:0]        x_reg;
    logic signed [16:0] y_reg;
    logic [7:0]         len_reg;
    logic [7:0]         even_reg;
    logic [7:0]         odd_reg;
    logic               last_reg;

    kind_t              pend_kind_reg;
    logic [15:0]        pend_x_reg;
    logic signed [16:0] pend_y_reg;

    // The register is free when empty or when its result is being transferred.
    assign take = !valid_reg || result_out.ready;
    assign pop  = take && !pend_reg && q_not_empty;

    always_comb
    begin
        valid_next = valid_reg;
        pend_next  = pend_reg;
        if (take)
        begin
            valid_next = pend_reg || q_not_empty;
            pend_next  = !pend_reg && q_not_empty && head.has_run && head.has_stat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (pend_reg)
            begin
                kind_reg <= pend_kind_reg;
                x_reg    <= pend_x_reg;
                y_reg    <= pend_y_reg;
                len_reg  <= '0;
                even_reg <= '0;
                odd_reg  <= '0;
                last_reg <= 1'b1;
            end
            else if (q_not_empty)
            begin
                if (head.has_run)
                begin
                    kind_reg <= KIND_RUN;
                    x_reg    <= head.run_x;
                    y_reg    <= head.run_y;
                    len_reg  <= head.run_len;
                    even_reg <= head.run_even;
                    odd_reg  <= head.run_odd;
                    last_reg <= !head.has_stat;
                end
                else
                begin
                    kind_reg <= head.stat_kind;
                    x_reg    <= head.stat_x;
                    y_reg    <= head.stat_y;
                    len_reg  <= '0;
                    even_reg <= '0;
                    odd_reg  <= '0;
                    last_reg <= 1'b1;
                end
                pend_kind_reg <= head.stat_kind;
                pend_x_reg    <= head.stat_x;
                pend_y_reg    <= head.stat_y;
            end
        end
    end

    assign result_out.valid        = valid_reg;
    assign result_out.kind         = kind_reg;
    assign result_out.start_x      = x_reg;
    assign result_out.row_y        = y_reg;
    assign result_out.run_length   = len_reg;
    assign result_out.even_index   = even_reg;
    assign result_out.odd_index    = odd_reg;
    assign result_out.last_of_item = last_reg;

endmodule

// ----- hw/rtl/bmp_rle_decoder.sv -----
// ----------------------------------------------------------------------------
// BMP RLE8/RLE4 pixel stream decoder
// Takes one compressed byte per cycle and issues pixel runs placed at a
// cursor, plus end-of-bitmap and truncation status. A byte is taken in every
// cycle while the four-entry command queue between the parser and the output
// register has room; a byte that closes a run and also ends the data early
// gives two results and holds the output side for two transfers. The cycle
// after a register write takes no byte while the parser restarts. Results
// leave through a registered output stage, so a stalled sink does not stop
// bytes being taken until the queue fills.
// ----------------------------------------------------------------------------
`include "bmp_rle_decoder_assert.svh"

module bmp_rle_decoder
    import bmp_rle_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    bmp_rle_byte_if.sink     byte_in,
    bmp_rle_result_if.source result_out
);

    logic               rle4_mode_reg;
    logic signed [16:0] height_reg;
    logic               restart_reg;
    logic               cfg_write;
    logic               reg_index;

    logic               q_push;
    logic               q_pop;
    rle_cmd_t           q_cmd_in;
    rle_cmd_t           q_head;
    queue_stat_t        q_stat;
    logic               front_finished;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[2];

    always_comb
    begin
        unique case (reg_index)
            REG_RLE4_MODE:     prdata = {31'd0, rle4_mode_reg};
            REG_SIGNED_HEIGHT: prdata = {15'd0, height_reg};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rle4_mode_reg <= 1'b0;
            height_reg    <= 17'sd1;
            restart_reg   <= 1'b0;
        end
        else
        begin
            // Any write restarts the parser on the following cycle.
            restart_reg <= cfg_write;
            if (cfg_write)
            begin
                unique case (reg_index)
                    REG_RLE4_MODE:     rle4_mode_reg <= pwdata[0];
                    REG_SIGNED_HEIGHT: height_reg    <= $signed(pwdata[16:0]);
                    default:           rle4_mode_reg <= rle4_mode_reg;
                endcase
            end
        end
    end

    bmp_rle_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .restart       (restart_reg),
        .rle4_mode     (rle4_mode_reg),
        .signed_height (height_reg),
        .in_valid      (byte_in.valid),
        .data_byte     (byte_in.data_byte),
        .end_of_data   (byte_in.end_of_data),
        .in_ready      (byte_in.ready),
        .q_space       (q_stat.has_space),
        .push          (q_push),
        .cmd           (q_cmd_in),
        .finished      (front_finished)
    );

    bmp_rle_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .cmd_in  (q_cmd_in),
        .pop     (q_pop),
        .cmd_out (q_head),
        .stat    (q_stat)
    );

    bmp_rle_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (q_head),
        .q_not_empty (q_stat.not_empty),
        .pop         (q_pop),
        .result_out  (result_out)
    );

    `BMP_RLE_ASSERT_SAME(a_push_has_room, q_push, q_stat.has_space)
    `BMP_RLE_ASSERT_SAME(a_pop_not_empty, q_pop, q_stat.not_empty)
    `BMP_RLE_ASSERT_NEXT(a_status_finishes, q_push && q_cmd_in.has_stat, front_finished)
    `BMP_RLE_ASSERT_SAME(a_status_is_last,
        result_out.valid && (result_out.kind != KIND_RUN), result_out.last_of_item)

endmodule

// ----- dv/tb_bmp_rle_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP RLE decoder testbench
// Feeds RLE8 and RLE4 byte streams through the byte channel and programs the
// mode and height registers over the APB port between images. Each result is
// compared field by field with a cycle-free model of the parser and cursor
// that is kept inside the bench. The streams include directed escapes, random
// well-formed images, noise, early ends and one image that drives the cursor
// into saturation. Random gaps and stalls are applied on both channels.
// ----------------------------------------------------------------------------
module tb_bmp_rle_decoder;
    import bmp_rle_pkg::*;

    localparam int  ITEM_TARGET  = 1850;
    localparam int  DRAIN_CYCLES = 16;
    localparam int  LONG_HOLD    = 400;
    // The longest quiet stretch of a correct run is the long hold on the result
    // side; sender gaps and stall patterns are far shorter.
    localparam int  QUIET_LIMIT  = 2000;
    localparam longint X_TOP     = (longint'(1) << 16) - 1;
    localparam longint Y_TOP     = (longint'(1) << 16) - 1;
    localparam longint Y_BOTTOM  = -(longint'(1) << 16);
    localparam logic [7:0] ESC_MARK = 8'h00;

    typedef enum logic [2:0] {
        PH_COUNT, PH_VALUE, PH_ESCAPE, PH_DX, PH_DY, PH_ABS, PH_PAD
    } parse_phase_t;

    typedef struct {
        logic [7:0] data;
        logic       eod;
        bit         drain;
    } rle_byte_t;

    typedef struct {
        kind_t              kind;
        logic [15:0]        start_x;
        logic signed [16:0] row_y;
        logic [7:0]         run_length;
        logic [7:0]         even_index;
        logic [7:0]         odd_index;
        logic               last_of_item;
    } rle_result_t;

    typedef logic [7:0] byte_list_t[$];

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bmp_rle_byte_if   byte_ch ();
    bmp_rle_result_if res_ch ();

    bmp_rle_decoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .byte_in    (byte_ch),
        .result_out (res_ch)
    );

    // Decoder state as the predictor sees it.
    logic               rle4_cfg;
    logic signed [16:0] height_cfg;
    parse_phase_t       phase_q;
    logic [7:0]         held_count;
    longint             cursor_x;
    longint             cursor_y;
    int                 abs_left;
    bit                 pad_due;
    bit                 finished_q;

    rle_byte_t   pending_bytes[$];
    rle_result_t exp_results[$];
    int          gen_count;
    int          bytes_offered;
    int          bytes_taken;
    bit          byte_busy;
    int          fail_count;
    int          quiet_cycles;
    bit          hold_request;
    bit          hold_done;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic longint clamp_row(input longint y);
        if (y > Y_TOP)
        begin
            return Y_TOP;
        end
        if (y < Y_BOTTOM)
        begin
            return Y_BOTTOM;
        end
        return y;
    endfunction

    function automatic longint row_step();
        return (height_cfg > 0) ? -1 : 1;
    endfunction

    function automatic void move_right(input longint d);
        cursor_x = cursor_x + d;
        if (cursor_x > X_TOP)
        begin
            cursor_x = X_TOP;
        end
    endfunction

    function automatic void restart_decoder();
        phase_q    = PH_COUNT;
        held_count = 8'd0;
        cursor_x   = 0;
        cursor_y   = clamp_row((height_cfg > 0) ? longint'(height_cfg) - 1 : 0);
        abs_left   = 0;
        pad_due    = 1'b0;
        finished_q = 1'b0;
    endfunction

    function automatic void apply_register(input logic reg_idx, input logic [31:0] value);
        if (reg_idx == REG_RLE4_MODE)
        begin
            rle4_cfg = value[0];
        end
        else
        begin
            height_cfg = value[16:0];
        end
        restart_decoder();
    endfunction

    function automatic rle_result_t make_result(input kind_t k, input logic [7:0] len,
                                                input logic [7:0] ev, input logic [7:0] od);
        rle_result_t r;
        r.kind         = k;
        r.start_x      = cursor_x[15:0];
        r.row_y        = cursor_y[16:0];
        r.run_length   = len;
        r.even_index   = ev;
        r.odd_index    = od;
        r.last_of_item = 1'b0;
        return r;
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic eod);
        rle_result_t outs[2];
        int          n;
        logic [7:0]  len;
        logic [7:0]  ev;
        logic [7:0]  od;
        n = 0;
        if (finished_q)
        begin
            return;
        end
        ev = rle4_cfg ? {4'h0, b[7:4]} : b;
        od = rle4_cfg ? {4'h0, b[3:0]} : b;
        case (phase_q)
            PH_COUNT:
            begin
                held_count = b;
                phase_q    = (b == ESC_MARK) ? PH_ESCAPE : PH_VALUE;
            end
            PH_VALUE:
            begin
                outs[n] = make_result(KIND_RUN, held_count, ev, od);
                n++;
                move_right(longint'(held_count));
                phase_q = PH_COUNT;
            end
            PH_ESCAPE:
            begin
                phase_q = PH_COUNT;
                if (b == ESC_END_OF_LINE)
                begin
                    cursor_x = 0;
                    cursor_y = clamp_row(cursor_y + row_step());
                end
                else if (b == ESC_END_OF_BMP)
                begin
                    outs[n] = make_result(KIND_END_OF_BMP, 8'd0, 8'd0, 8'd0);
                    n++;
                    finished_q = 1'b1;
                end
                else if (b == ESC_DELTA)
                begin
                    phase_q = PH_DX;
                end
                else
                begin
                    abs_left = int'(b);
                    // In RLE4 the padding follows the byte count, not the pixel count.
                    pad_due  = rle4_cfg ? ((((int'(b) + 1) / 2) % 2) != 0) : b[0];
                    phase_q  = PH_ABS;
                end
            end
            PH_DX:
            begin
                held_count = b;
                phase_q    = PH_DY;
            end
            PH_DY:
            begin
                move_right(longint'(held_count));
                cursor_y = clamp_row(cursor_y + row_step() * longint'(b));
                phase_q  = PH_COUNT;
            end
            PH_ABS:
            begin
                len = (rle4_cfg && abs_left >= 2) ? 8'd2 : 8'd1;
                outs[n] = make_result(KIND_RUN, len, ev, od);
                n++;
                move_right(longint'(len));
                abs_left = (abs_left > int'(len)) ? abs_left - int'(len) : 0;
                if (abs_left == 0)
                begin
                    phase_q = pad_due ? PH_PAD : PH_COUNT;
                    pad_due = 1'b0;
                end
            end
            default:
            begin
                phase_q = PH_COUNT;
            end
        endcase
        if (eod && !finished_q)
        begin
            outs[n] = make_result(KIND_TRUNCATED, 8'd0, 8'd0, 8'd0);
            n++;
            finished_q = 1'b1;
        end
        if (n > 0)
        begin
            outs[n - 1].last_of_item = 1'b1;
        end
        for (int i = 0; i < n; i++)
        begin
            exp_results.push_back(outs[i]);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stream building
    // ------------------------------------------------------------------------
    function automatic void push_byte(input logic [7:0] b, input logic eod, input bit drain);
        rle_byte_t it;
        it.data  = b;
        it.eod   = eod;
        it.drain = drain;
        pending_bytes.push_back(it);
        gen_count++;
    endfunction

    function automatic void push_rand(input logic [7:0] b);
        push_byte(b, 1'b0, $urandom_range(0, 199) == 0);
    endfunction

    function automatic void push_list(input byte_list_t seq, input logic eod_last);
        foreach (seq[i])
        begin
            push_byte(seq[i], eod_last && (i == seq.size() - 1), 1'b0);
        end
    endfunction

    function automatic logic [7:0] pick_count();
        case ($urandom_range(0, 7))
            0:       return 8'd255;
            1:       return 8'd254;
            2:       return 8'd1;
            3:       return 8'($urandom_range(1, 255));
            default: return 8'($urandom_range(1, 16));
        endcase
    endfunction

    function automatic logic signed [16:0] pick_height();
        case ($urandom_range(0, 7))
            0:       return 17'sd65535;
            1:       return -17'sd65535;
            2:       return 17'sd0;
            3:       return 17'sd1;
            4:       return -17'sd1;
            default: return 17'($urandom_range(0, 131070) - 65535);
        endcase
    endfunction

    function automatic void queue_image(input logic rle4, input int n_ops);
        int         pick;
        int         cnt;
        int         nbytes;
        bit         ended;
        rle_byte_t  tail;
        for (int i = 0; i < n_ops; i++)
        begin
            pick = $urandom_range(0, 19);
            if (pick <= 8)
            begin
                push_rand(pick_count());
                push_rand(8'($urandom));
            end
            else if (pick <= 10)
            begin
                push_rand(ESC_MARK);
                push_rand(ESC_END_OF_LINE);
            end
            else if (pick <= 12)
            begin
                push_rand(ESC_MARK);
                push_rand(ESC_DELTA);
                push_rand(8'($urandom));
                push_rand(8'($urandom));
            end
            else if (pick <= 17)
            begin
                cnt    = ($urandom_range(0, 15) == 0) ? $urandom_range(3, 255)
                                                      : $urandom_range(3, 12);
                nbytes = rle4 ? (cnt + 1) / 2 : cnt;
                push_rand(ESC_MARK);
                push_rand(8'(cnt));
                for (int k = 0; k < nbytes; k++)
                begin
                    push_rand(8'($urandom));
                end
                if ((nbytes % 2) != 0)
                begin
                    push_rand(8'($urandom));
                end
            end
            else
            begin
                // Stray bytes knock the parser off the pair boundary.
                push_rand(8'($urandom));
            end
        end
        ended = 1'b1;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4:
            begin
                push_rand(ESC_MARK);
                push_rand(ESC_END_OF_BMP);
            end
            5:
            begin
                push_rand(ESC_MARK);
                push_byte(ESC_END_OF_BMP, 1'b1, 1'b0);
            end
            6, 7, 8:
            begin
                tail = pending_bytes.pop_back();
                tail.eod = 1'b1;
                pending_bytes.push_back(tail);
            end
            default:
            begin
                ended = 1'b0;
            end
        endcase
        if (ended)
        begin
            repeat ($urandom_range(0, 2))
            begin
                push_byte(8'($urandom), 1'($urandom), 1'b0);
            end
        end
    endfunction

    // Enough full-size deltas to pin both coordinates at their limits.
    function automatic void queue_far_deltas();
        for (int i = 0; i < 264; i++)
        begin
            if ((i % 32) == 0)
            begin
                push_rand(pick_count());
                push_rand(8'($urandom));
            end
            push_rand(ESC_MARK);
            push_rand(ESC_DELTA);
            push_rand(8'hFF);
            push_rand(8'hFF);
        end
        push_rand(8'd9);
        push_rand(8'($urandom));
        push_rand(ESC_MARK);
        push_rand(ESC_END_OF_LINE);
        push_rand(8'd3);
        push_rand(8'($urandom));
        push_rand(ESC_MARK);
        push_rand(ESC_END_OF_BMP);
    endfunction

    // ------------------------------------------------------------------------
    // Register access and phase control
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic reg_idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        apply_register(reg_idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_height(input logic signed [16:0] h);
        write_reg(REG_SIGNED_HEIGHT, {{15{h[16]}}, h});
    endtask

    task automatic write_mode(input logic mode);
        write_reg(REG_RLE4_MODE, {31'd0, mode});
    endtask

    // Waits until every byte is taken and every result is back, then lets the
    // block finish any byte that gave no result.
    task automatic settle();
        while (pending_bytes.size() != 0 || byte_busy || exp_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Byte driver: bursts of transfers separated by random gaps
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : byte_driver
        rle_byte_t cur;
        int        burst_left;
        int        gap_left;
        if (rst_n)
        begin
            if (byte_busy && bytes_taken == bytes_offered)
            begin
                byte_busy = 1'b0;
            end
            if (!byte_busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pending_bytes.size() != 0 &&
                         (!pending_bytes[0].drain || exp_results.size() == 0))
                begin
                    cur = pending_bytes.pop_front();
                    byte_busy = 1'b1;
                    bytes_offered++;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
            byte_ch.valid       <= byte_busy;
            byte_ch.data_byte   <= cur.data;
            byte_ch.end_of_data <= cur.eod;
        end
    end

    // ------------------------------------------------------------------------
    // Result sink: rotating stall pattern, plus one long hold on request
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : result_sink
        logic [31:0] stall_pattern;
        int          pattern_age;
        int          hold_left;
        if (rst_n)
        begin
            if (hold_request && !hold_done)
            begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (pattern_age == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       stall_pattern = '0;
                    1:       stall_pattern = $urandom;
                    2:       stall_pattern = $urandom & $urandom;
                    default: stall_pattern = $urandom | $urandom;
                endcase
            end
            pattern_age = (pattern_age + 1) % 64;
            if (hold_left > 0)
            begin
                hold_left--;
            end
            res_ch.ready  <= (hold_left == 0) && !stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[31:1]};
        end
    end

    // ------------------------------------------------------------------------
    // Monitor, checker and watchdog
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input longint want_v,
                                        input longint got_v);
        if (want_v != got_v)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, want_v, got_v);
        end
    endfunction

    always @(posedge clk)
    begin : stream_monitor
        rle_result_t want;
        bit          moved;
        if (rst_n)
        begin
            moved = psel;
            if (byte_ch.valid && byte_ch.ready)
            begin
                decode_byte(byte_ch.data_byte, byte_ch.end_of_data);
                bytes_taken++;
                moved = 1'b1;
            end
            if (res_ch.valid && res_ch.ready)
            begin
                moved = 1'b1;
                if (exp_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, actual kind %0d x %0d",
                             $time, res_ch.kind, res_ch.start_x);
                end
                else
                begin
                    want = exp_results.pop_front();
                    check_field("kind", want.kind, res_ch.kind);
                    check_field("start_x", want.start_x, res_ch.start_x);
                    check_field("row_y", want.row_y, res_ch.row_y);
                    check_field("run_length", want.run_length, res_ch.run_length);
                    check_field("even_index", want.even_index, res_ch.even_index);
                    check_field("odd_index", want.odd_index, res_ch.odd_index);
                    check_field("last_of_item", want.last_of_item, res_ch.last_of_item);
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin : test_sequence
        byte_list_t seq;
        logic       next_mode;
        int         which;

        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        byte_ch.valid       = 1'b0;
        byte_ch.data_byte   = '0;
        byte_ch.end_of_data = 1'b0;
        res_ch.ready        = 1'b0;
        fail_count          = 0;
        gen_count           = 0;
        bytes_offered       = 0;
        bytes_taken         = 0;
        byte_busy           = 1'b0;
        quiet_cycles        = 0;
        hold_request        = 1'b0;
        hold_done           = 1'b0;
        rle4_cfg            = 1'b0;
        height_cfg          = 17'sd1;
        restart_decoder();

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // RLE8, tallest bottom-up image: long run, end of line, delta, padded
        // absolute run, end of bitmap and a byte that must be ignored after it.
        write_mode(1'b0);
        write_height(17'sd65535);
        seq = '{8'hFF, 8'h00,
                ESC_MARK, ESC_END_OF_LINE,
                ESC_MARK, ESC_DELTA, 8'h05, 8'h03,
                ESC_MARK, 8'h03, 8'hFF, 8'h80, 8'h01, 8'h00,
                ESC_MARK, ESC_END_OF_BMP,
                8'h7F};
        push_list(seq, 1'b0);
        settle();

        // RLE4 top-down: odd encoded count, absolute run with padding, and a
        // run byte that also ends the data early.
        write_mode(1'b1);
        write_height(-17'sd1);
        seq = '{8'h05, 8'hA5,
                ESC_MARK, 8'h05, 8'h12, 8'h34, 8'h56, 8'h00,
                8'h04, 8'hC3};
        push_list(seq, 1'b1);
        settle();

        // Data ending on an escape marker, at zero height.
        write_height(17'sd0);
        seq = '{ESC_MARK};
        push_list(seq, 1'b1);
        settle();

        // Cursor saturation in either vertical direction.
        write_mode(1'($urandom));
        write_height($urandom_range(0, 1) ? -17'sd65535 : 17'sd1);
        queue_far_deltas();
        settle();

        // Random images; the first one runs under the long result hold.
        write_mode(1'b0);
        write_height(pick_height());
        hold_request = 1'b1;
        queue_image(rle4_cfg, 40);
        settle();
        while (gen_count < ITEM_TARGET)
        begin
            which     = $urandom_range(0, 2);
            next_mode = 1'($urandom);
            if (which != 2)
            begin
                write_mode(next_mode);
            end
            if (which != 1)
            begin
                write_height(pick_height());
            end
            queue_image(rle4_cfg, $urandom_range(4, 40));
            settle();
        end

        if (exp_results.size() != 0)
        begin
            fail_count++;
            $display("%0t: results outstanding, expected 0, actual %0d",
                     $time, exp_results.size());
        end
        if (fail_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
